>>> rtl/tlg_pkg.sv
// Shared types and constants of the toroidal Life grid engine.
package tlg_pkg;

   // Opcodes of an input item
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Configuration register indexes
   localparam int         CSR_INDEX_W   = 1;
   localparam int         CSR_DATA_W    = 7;
   localparam logic [0:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [0:0] CSR_GRID_COLS = 1'b1;

   // Width of the coordinate fields
   localparam int COORD_W = 8;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_MOD,
      ST_CLR,
      ST_SET_RD,
      ST_SET_WR,
      ST_GET_RD,
      ST_GET_CAP,
      ST_STEP_UP,
      ST_STEP_MID,
      ST_STEP_DN,
      ST_STEP_WR,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_MOD,
      DP_CLR_WR,
      DP_SET_RD,
      DP_SET_WR,
      DP_GET_RD,
      DP_GET_CAP,
      DP_STEP_UP,
      DP_STEP_MID,
      DP_STEP_DN,
      DP_STEP_WR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      load_item;
      logic      row_next;
      logic      flip;
      logic      load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       mod_last;
      logic       row_last_all;
      logic       row_last_used;
      logic       rsp_free;
   } status_type;

endpackage

>>> rtl/tlg_req_if.sv
// Request channel of the Life grid engine: valid, ready and one input item.
interface tlg_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] row;
   logic [7:0] col;
   logic       alive;

   modport source (output valid, output opcode, output row, output col, output alive,
                   input ready);
   modport sink   (input valid, input opcode, input row, input col, input alive,
                   output ready);
endinterface

>>> rtl/tlg_rsp_if.sv
// Response channel of the Life grid engine: valid, ready and one result item.
interface tlg_rsp_if;
   logic       valid;
   logic       ready;
   logic       cell_alive;
   logic [1:0] done_opcode;

   modport source (output valid, output cell_alive, output done_opcode, input ready);
   modport sink   (input valid, input cell_alive, input done_opcode, output ready);
endinterface

>>> rtl/tlg_ram.sv
// Generic single write port RAM with one registered read port.
module tlg_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/tlg_ctrl.sv
// Sequencer of the Life grid engine: walks each opcode through the datapath.
module tlg_ctrl
   import tlg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT_CLR: if (status.row_last_all) state_in = ST_IDLE;
         ST_IDLE:     if (req_valid) state_in = ST_MOD;
         ST_MOD: begin
            if (status.mod_last) begin
               case (status.opcode)
                  OP_CLEAR: state_in = ST_CLR;
                  OP_SET:   state_in = ST_SET_RD;
                  OP_STEP:  state_in = ST_STEP_UP;
                  OP_READ:  state_in = ST_GET_RD;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_CLR:      if (status.row_last_all) state_in = ST_DONE;
         ST_SET_RD:   state_in = ST_SET_WR;
         ST_SET_WR:   state_in = ST_DONE;
         ST_GET_RD:   state_in = ST_GET_CAP;
         ST_GET_CAP:  state_in = ST_DONE;
         ST_STEP_UP:  state_in = ST_STEP_MID;
         ST_STEP_MID: state_in = ST_STEP_DN;
         ST_STEP_DN:  state_in = ST_STEP_WR;
         ST_STEP_WR:  state_in = status.row_last_used ? ST_DONE : ST_STEP_UP;
         ST_DONE:     if (status.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_INIT_CLR;
      endcase
   end

   // Commands per state
   always_comb begin
      cmd       = '0;
      cmd.op    = DP_NOP;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT_CLR, ST_CLR: begin
            cmd.op       = DP_CLR_WR;
            cmd.row_next = 1'b1;
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_MOD:      cmd.op = DP_MOD;
         ST_SET_RD:   cmd.op = DP_SET_RD;
         ST_SET_WR:   cmd.op = DP_SET_WR;
         ST_GET_RD:   cmd.op = DP_GET_RD;
         ST_GET_CAP:  cmd.op = DP_GET_CAP;
         ST_STEP_UP:  cmd.op = DP_STEP_UP;
         ST_STEP_MID: cmd.op = DP_STEP_MID;
         ST_STEP_DN:  cmd.op = DP_STEP_DN;
         ST_STEP_WR: begin
            cmd.op       = DP_STEP_WR;
            cmd.row_next = 1'b1;
            cmd.flip     = status.row_last_used;
         end
         ST_DONE:     cmd.load_rsp = status.rsp_free;
         default:     cmd.op = DP_NOP;
      endcase
   end
endmodule

>>> rtl/tlg_datapath.sv
// Datapath of the Life grid engine: size registers, modulo unit, grid banks, row update.
module tlg_datapath
   import tlg_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [1:0]             item_opcode,
   input  logic [COORD_W-1:0]     item_row,
   input  logic [COORD_W-1:0]     item_col,
   input  logic                   item_alive,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_cell_alive,
   output logic [1:0]             rsp_done_opcode,
   input  cmd_type                cmd,
   output status_type             status
);
   localparam int AW_R = $clog2(MAX_ROWS);
   localparam int AW_C = $clog2(MAX_COLS);
   localparam int SW_R = $clog2(MAX_ROWS + 1);
   localparam int SW_C = $clog2(MAX_COLS + 1);

   logic [CSR_DATA_W-1:0] rows_ff, cols_ff;
   logic [SW_R-1:0]       eff_r;
   logic [SW_C-1:0]       eff_c;
   logic [AW_R-1:0]       nr_m1;
   logic [AW_C-1:0]       nc_m1;

   logic [1:0]            op_ff;
   logic [COORD_W-1:0]    row_ff, col_ff;
   logic                  alive_ff;
   logic [2:0]            mod_cnt_ff;
   logic [SW_R-1:0]       rem_r_ff, rem_r_in;
   logic [SW_C-1:0]       rem_c_ff, rem_c_in;
   logic [SW_R:0]         sh_r;
   logic [SW_C:0]         sh_c;
   logic [AW_R-1:0]       r_idx;
   logic [AW_C-1:0]       c_idx;

   logic [AW_R-1:0]       line_ff, line_up, line_dn;
   logic                  sel_ff;
   logic                  cell_ff;
   logic                  rsp_valid_ff, rsp_alive_ff;
   logic [1:0]            rsp_op_ff;

   logic [MAX_COLS-1:0]   up_ff, mid_ff, old_ff;
   logic [MAX_COLS-1:0]   live_rd, work_rd, rd0, rd1;
   logic [MAX_COLS-1:0]   set_row, next_row;

   logic                  clr_we, live_we, work_we;
   logic [AW_R-1:0]       live_raddr, work_raddr, live_waddr;
   logic [MAX_COLS-1:0]   live_wdata;
   logic                  we0, we1;
   logic [AW_R-1:0]       wa0, wa1, ra0, ra1;
   logic [MAX_COLS-1:0]   wd0, wd1;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CSR_DATA_W'(64);
         cols_ff <= CSR_DATA_W'(64);
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRID_ROWS: rows_ff <= csr_wdata;
            CSR_GRID_COLS: cols_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // Clamp sizes into the supported range
   always_comb begin
      if (rows_ff == '0) begin
         eff_r = SW_R'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         eff_r = SW_R'(MAX_ROWS);
      end else begin
         eff_r = SW_R'(rows_ff);
      end
      if (cols_ff == '0) begin
         eff_c = SW_C'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         eff_c = SW_C'(MAX_COLS);
      end else begin
         eff_c = SW_C'(cols_ff);
      end
   end

   assign nr_m1 = AW_R'(eff_r - SW_R'(1));
   assign nc_m1 = AW_C'(eff_c - SW_C'(1));

   // Latch the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff    <= item_opcode;
         row_ff   <= item_row;
         col_ff   <= item_col;
         alive_ff <= item_alive;
      end
   end

   // Restoring remainder, one coordinate bit per cycle
   always_comb begin
      sh_r = {rem_r_ff, row_ff[3'd7 - mod_cnt_ff]};
      sh_c = {rem_c_ff, col_ff[3'd7 - mod_cnt_ff]};
      if (sh_r >= {1'b0, eff_r}) begin
         rem_r_in = SW_R'(sh_r - {1'b0, eff_r});
      end else begin
         rem_r_in = sh_r[SW_R-1:0];
      end
      if (sh_c >= {1'b0, eff_c}) begin
         rem_c_in = SW_C'(sh_c - {1'b0, eff_c});
      end else begin
         rem_c_in = sh_c[SW_C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_cnt_ff <= '0;
         rem_r_ff   <= '0;
         rem_c_ff   <= '0;
      end else if (cmd.load_item) begin
         mod_cnt_ff <= '0;
         rem_r_ff   <= '0;
         rem_c_ff   <= '0;
      end else if (cmd.op == DP_MOD) begin
         mod_cnt_ff <= mod_cnt_ff + 3'd1;
         rem_r_ff   <= rem_r_in;
         rem_c_ff   <= rem_c_in;
      end
   end

   assign r_idx = rem_r_ff[AW_R-1:0];
   assign c_idx = rem_c_ff[AW_C-1:0];

   // Row counter and bank select
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         sel_ff  <= 1'b0;
      end else begin
         if (cmd.load_item) begin
            line_ff <= '0;
         end else if (cmd.row_next) begin
            line_ff <= line_ff + AW_R'(1);
         end
         if (cmd.flip) begin
            sel_ff <= ~sel_ff;
         end
      end
   end

   assign line_up = (line_ff == '0) ? nr_m1 : line_ff - AW_R'(1);
   assign line_dn = (line_ff == nr_m1) ? '0 : line_ff + AW_R'(1);

   // Capture the neighbor rows and old work row of a step, and the cell bit of a read
   always_ff @(posedge clock) begin
      if (cmd.op == DP_STEP_MID) begin
         up_ff  <= live_rd;
         old_ff <= work_rd;
      end
      if (cmd.op == DP_STEP_DN) begin
         mid_ff <= live_rd;
      end
      if (cmd.op == DP_GET_CAP) begin
         cell_ff <= live_rd[c_idx];
      end
   end

   // Next generation of one row, masked to the columns in use
   always_comb begin
      logic       ul, ur, ml, mr, dl, dr;
      logic [3:0] n;
      next_row = old_ff;
      for (int j = 0; j < MAX_COLS; j++) begin
         if (j == 0) begin
            ul = up_ff[nc_m1];
            ml = mid_ff[nc_m1];
            dl = live_rd[nc_m1];
         end else begin
            ul = up_ff[(j + MAX_COLS - 1) % MAX_COLS];
            ml = mid_ff[(j + MAX_COLS - 1) % MAX_COLS];
            dl = live_rd[(j + MAX_COLS - 1) % MAX_COLS];
         end
         if (AW_C'(j) == nc_m1) begin
            ur = up_ff[0];
            mr = mid_ff[0];
            dr = live_rd[0];
         end else begin
            ur = up_ff[(j + 1) % MAX_COLS];
            mr = mid_ff[(j + 1) % MAX_COLS];
            dr = live_rd[(j + 1) % MAX_COLS];
         end
         n = {3'b0, ul} + {3'b0, up_ff[j]} + {3'b0, ur} + {3'b0, ml} + {3'b0, mr}
           + {3'b0, dl} + {3'b0, live_rd[j]} + {3'b0, dr};
         if (AW_C'(j) <= nc_m1) begin
            next_row[j] = (n == 4'd3) || (mid_ff[j] && (n == 4'd2));
         end
      end
   end

   // Patch one cell into its row
   always_comb begin
      set_row        = live_rd;
      set_row[c_idx] = alive_ff;
   end

   // Bank addressing: live and work views mapped onto the two RAMs
   always_comb begin
      clr_we     = (cmd.op == DP_CLR_WR);
      live_we    = (cmd.op == DP_SET_WR);
      work_we    = (cmd.op == DP_STEP_WR);
      live_waddr = r_idx;
      live_wdata = set_row;
      work_raddr = line_ff;
      case (cmd.op)
         DP_STEP_UP:  live_raddr = line_up;
         DP_STEP_MID: live_raddr = line_ff;
         DP_STEP_DN:  live_raddr = line_dn;
         default:     live_raddr = r_idx;
      endcase
      we0 = clr_we | (live_we & ~sel_ff) | (work_we & sel_ff);
      we1 = clr_we | (live_we & sel_ff) | (work_we & ~sel_ff);
      if (clr_we) begin
         wa0 = line_ff;
         wa1 = line_ff;
         wd0 = '0;
         wd1 = '0;
      end else if (sel_ff) begin
         wa0 = line_ff;
         wd0 = next_row;
         wa1 = live_waddr;
         wd1 = live_wdata;
      end else begin
         wa0 = live_waddr;
         wd0 = live_wdata;
         wa1 = line_ff;
         wd1 = next_row;
      end
      ra0     = sel_ff ? work_raddr : live_raddr;
      ra1     = sel_ff ? live_raddr : work_raddr;
      live_rd = sel_ff ? rd1 : rd0;
      work_rd = sel_ff ? rd0 : rd1;
   end

   tlg_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (wa0),
      .wr_data (wd0),
      .rd_addr (ra0),
      .rd_data (rd0)
   );

   tlg_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (wa1),
      .wr_data (wd1),
      .rd_addr (ra1),
      .rd_data (rd1)
   );

   // Result register: load on completion, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_alive_ff <= (op_ff == OP_READ) ? cell_ff : 1'b0;
         rsp_op_ff    <= op_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_alive  = rsp_alive_ff;
   assign rsp_done_opcode = rsp_op_ff;

   // Status back to the sequencer
   always_comb begin
      status.opcode        = op_ff;
      status.mod_last      = (mod_cnt_ff == 3'd7);
      status.row_last_all  = (line_ff == AW_R'(MAX_ROWS - 1));
      status.row_last_used = (line_ff == nr_m1);
      status.rsp_free      = ~rsp_valid_ff | rsp_ready;
   end
endmodule

>>> rtl/toroidal_life_grid_engine.sv
// Top level of the toroidal Life grid engine (B3/S23 on a wrapped grid).
//
// Requests arrive on req_chan (opcode, row, col, alive) and each one yields
// exactly one response on rsp_chan (cell_alive, done_opcode); a transfer
// happens when valid and ready are both high. Grid size is set through the
// csr_ port (index 0 rows, index 1 columns); the user must write it only
// while the engine is idle, and the block itself does not enforce this.
// Items are worked one at a time. Every item first has its coordinates
// reduced in a bit-serial remainder unit, then:
//   set or read: a row read, then a row write or a bit capture;
//   clear: all MAX_ROWS rows, one row of both grid banks per cycle;
//   step: for each row in use the three neighbor rows are fetched in turn,
//         since the live bank RAM has one read port, then the row is written.
// Last, the response register is loaded. After reset the engine clears both
// grid banks one row per cycle, all MAX_ROWS rows, with req_chan.ready low.
// A stalled receiver keeps the response held; the next request is still
// taken and worked, and it completes once the held response has been transferred.
module toroidal_life_grid_engine
   import tlg_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   tlg_req_if.sink                req_chan,
   tlg_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);
   cmd_type    cmd;
   status_type status;
   logic       ready;

   tlg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   tlg_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .item_opcode     (req_chan.opcode),
      .item_row        (req_chan.row),
      .item_col        (req_chan.col),
      .item_alive      (req_chan.alive),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_cell_alive  (rsp_chan.cell_alive),
      .rsp_done_opcode (rsp_chan.done_opcode),
      .cmd             (cmd),
      .status          (status)
   );

   assign req_chan.ready = ready;
endmodule

>>> tb/tb_channels.sv
// Item types shared by the testbench of the toroidal Life grid engine.
`timescale 1ns / 1ps
package tb_life_pkg;
   import tlg_pkg::*;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] row;
      logic [7:0] col;
      logic       alive;
   } life_cmd_type;

   typedef struct packed {
      logic       cell_alive;
      logic [1:0] done_opcode;
   } life_rsp_type;
endpackage

>>> tb/testbench.sv
// Self-checking testbench of the toroidal Life grid engine with a behavioral grid predictor.
`timescale 1ns / 1ps
module testbench;
   import tlg_pkg::*;
   import tb_life_pkg::*;

   localparam int NROW = 64;
   localparam int NCOL = 64;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tlg_req_if req_chan ();
   tlg_rsp_if rsp_chan ();

   toroidal_life_grid_engine DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic bank [2][NROW*NCOL];
   logic live_sel;
   logic [6:0] rows_reg, cols_reg;
   life_rsp_type pending_rsp[$];
   int errors, n_sent, n_got, n_steps, n_reads, idle_cycles;
   bit rsp_stall_en;

   function automatic int eff_size(logic [6:0] v, int mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   function automatic life_rsp_type apply_cmd(life_cmd_type c);
      life_rsp_type res;
      int nr, nc, r, cc, n, rr, kk;
      logic was;
      nr = eff_size(rows_reg, NROW);
      nc = eff_size(cols_reg, NCOL);
      r = c.row % nr;
      cc = c.col % nc;
      res.cell_alive = 1'b0;
      res.done_opcode = c.opcode;
      case (c.opcode)
         OP_CLEAR: begin
            for (int i = 0; i < NROW*NCOL; i++) begin
               bank[0][i] = 1'b0;
               bank[1][i] = 1'b0;
            end
         end
         OP_SET: bank[live_sel][r*NCOL+cc] = c.alive;
         OP_STEP: begin
            for (int i = 0; i < nr; i++)
               for (int j = 0; j < nc; j++) begin
                  n = 0;
                  for (int dr = 0; dr < 3; dr++)
                     for (int dc = 0; dc < 3; dc++) begin
                        if (dr == 1 && dc == 1) continue;
                        rr = (i + nr + dr - 1) % nr;
                        kk = (j + nc + dc - 1) % nc;
                        n += bank[live_sel][rr*NCOL+kk];
                     end
                  was = bank[live_sel][i*NCOL+j];
                  bank[!live_sel][i*NCOL+j] = (n == 3 || (was && n == 2));
               end
            live_sel = !live_sel;
         end
         default: res.cell_alive = bank[live_sel][r*NCOL+cc];
      endcase
      return res;
   endfunction

   task automatic report(string what, logic [3:0] got, logic [3:0] want);
      $display("mismatch %s: got %0d expected %0d (response %0d)", what, got, want, n_got);
      errors++;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: stall pattern, check each transfer
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            life_rsp_type want;
            n_got++;
            if (pending_rsp.size() == 0) begin
               $display("mismatch: response with nothing outstanding");
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_chan.done_opcode !== want.done_opcode)
                  report("done_opcode", rsp_chan.done_opcode, want.done_opcode);
               if (rsp_chan.cell_alive !== want.cell_alive)
                  report("cell_alive", rsp_chan.cell_alive, want.cell_alive);
            end
         end
         rsp_chan.ready <= rsp_stall_en ? (($urandom_range(0, 7) > 2) ||
                           (n_got % 16 > 11)) : 1'b1;
      end
   end

   // watchdog: cycles without any transfer
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL toroidal_life_grid_engine");
            $finish;
         end
      end
   end

   // send one item: hold valid until transfer
   task automatic send_cmd(life_cmd_type c);
      req_chan.valid <= 1'b1;
      req_chan.opcode <= c.opcode;
      req_chan.row <= c.row;
      req_chan.col <= c.col;
      req_chan.alive <= c.alive;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      pending_rsp.push_back(apply_cmd(c));
      n_sent++;
      if (c.opcode == OP_STEP) n_steps++;
      if (c.opcode == OP_READ) n_reads++;
   endtask

   task automatic release_req();
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      release_req();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one register write, then the port is left quiet
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [6:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GRID_ROWS) rows_reg = val;
      else cols_reg = val;
      @(posedge clock);
   endtask

   // random item, mostly inside the grid so patterns evolve
   function automatic life_cmd_type rand_cmd(int nr, int nc);
      life_cmd_type c;
      int p;
      p = $urandom_range(0, 99);
      c.opcode = (p < 45) ? OP_SET : (p < 75) ? OP_READ : (p < 97) ? OP_STEP : OP_CLEAR;
      if ($urandom_range(0, 9) == 0) begin
         c.row = $urandom_range(0, 255);
         c.col = $urandom_range(0, 255);
      end else begin
         c.row = $urandom_range(0, nr - 1);
         c.col = $urandom_range(0, nc - 1);
      end
      c.alive = ($urandom_range(0, 3) != 0);
      return c;
   endfunction

   typedef struct {
      life_cmd_type cmd;
      bit           typed;
      life_rsp_type want;
   } dir_row_type;

   initial begin
      dir_row_type dir_tbl[$];
      life_cmd_type c;
      life_rsp_type got_pred;
      int nr, nc, burst, gap;
      logic [6:0] size_set[6][2];

      errors = 0; n_sent = 0; n_got = 0; n_steps = 0; n_reads = 0;
      rsp_stall_en = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0; csr_index = '0; csr_wdata = '0;
      req_chan.valid = 1'b0; req_chan.opcode = OP_CLEAR;
      req_chan.row = '0; req_chan.col = '0; req_chan.alive = 1'b0;
      for (int i = 0; i < NROW*NCOL; i++) begin
         bank[0][i] = 1'b0;
         bank[1][i] = 1'b0;
      end
      live_sel = 1'b0; rows_reg = 7'd64; cols_reg = 7'd64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reads after reset, extremes, blinker, wrap at max coordinates
      dir_tbl.push_back('{'{OP_READ, 8'd0, 8'd0, 1'b0}, 1, '{1'b0, OP_READ}});
      dir_tbl.push_back('{'{OP_READ, 8'd255, 8'd255, 1'b1}, 1, '{1'b0, OP_READ}});
      dir_tbl.push_back('{'{OP_SET, 8'd255, 8'd255, 1'b1}, 1, '{1'b0, OP_SET}});
      dir_tbl.push_back('{'{OP_READ, 8'd63, 8'd63, 1'b0}, 1, '{1'b1, OP_READ}});
      dir_tbl.push_back('{'{OP_SET, 8'd63, 8'd0, 1'b1}, 0, '{1'b0, OP_SET}});
      dir_tbl.push_back('{'{OP_SET, 8'd63, 8'd1, 1'b1}, 0, '{1'b0, OP_SET}});
      dir_tbl.push_back('{'{OP_STEP, 8'd0, 8'd0, 1'b0}, 1, '{1'b0, OP_STEP}});
      dir_tbl.push_back('{'{OP_READ, 8'd62, 8'd0, 1'b0}, 0, '{1'b0, OP_READ}});
      dir_tbl.push_back('{'{OP_READ, 8'd0, 8'd0, 1'b0}, 0, '{1'b0, OP_READ}});
      dir_tbl.push_back('{'{OP_SET, 8'd128, 8'd128, 1'b0}, 1, '{1'b0, OP_SET}});
      dir_tbl.push_back('{'{OP_STEP, 8'd170, 8'd85, 1'b1}, 0, '{1'b0, OP_STEP}});
      dir_tbl.push_back('{'{OP_READ, 8'd63, 8'd0, 1'b0}, 0, '{1'b0, OP_READ}});
      dir_tbl.push_back('{'{OP_CLEAR, 8'd255, 8'd255, 1'b1}, 1, '{1'b0, OP_CLEAR}});
      dir_tbl.push_back('{'{OP_READ, 8'd63, 8'd63, 1'b0}, 1, '{1'b0, OP_READ}});
      foreach (dir_tbl[k]) begin
         got_pred = '0;
         send_cmd(dir_tbl[k].cmd);
         got_pred = pending_rsp[$];
         if (dir_tbl[k].typed && got_pred !== dir_tbl[k].want) begin
            $display("mismatch: directed row %0d disagrees with predictor", k);
            errors++;
         end
      end
      // hold off until every response is in
      drain();

      // size settings: extremes, out of range, and odd shapes
      size_set = '{'{7'd1, 7'd1}, '{7'd0, 7'd127}, '{7'd3, 7'd5},
                   '{7'd8, 7'd8}, '{7'd64, 7'd2}, '{7'd64, 7'd64}};
      rsp_stall_en = 1'b1;
      for (int s = 0; s < 6; s++) begin
         write_csr(CSR_GRID_ROWS, size_set[s][0]);
         write_csr(CSR_GRID_COLS, size_set[s][1]);
         nr = eff_size(rows_reg, NROW);
         nc = eff_size(cols_reg, NCOL);
         // clear first: no enlarged region may expose unwritten work cells
         send_cmd('{OP_CLEAR, 8'd0, 8'd0, 1'b0});
         for (int k = 0; k < ((s == 5) ? 12 : 19); ) begin
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst; b++) begin
               c = rand_cmd(nr, nc);
               if (s == 5 && c.opcode == OP_STEP && $urandom_range(0, 2) != 0)
                  c.opcode = OP_SET;
               send_cmd(c);
               k++;
            end
            // idle gap between bursts; no gap keeps valid high
            gap = $urandom_range(0, 30);
            if (gap > 0) begin
               release_req();
               repeat (gap) @(posedge clock);
            end
         end
         if (s == 2) rsp_stall_en = 1'b0;
         if (s == 3) rsp_stall_en = 1'b1;
         drain();
      end

      $display("covered %0d items, %0d generation steps, %0d reads over six grid sizes",
               n_sent, n_steps, n_reads);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("PASS toroidal_life_grid_engine");
      else
         $display("FAIL toroidal_life_grid_engine");
      $finish;
   end
endmodule

>>> filelist.f
rtl/tlg_pkg.sv
rtl/tlg_req_if.sv
rtl/tlg_rsp_if.sv
rtl/tlg_ram.sv
rtl/tlg_ctrl.sv
rtl/tlg_datapath.sv
rtl/toroidal_life_grid_engine.sv
tb/tb_channels.sv
tb/testbench.sv
